@@ src/frk_pkg.sv @@
// Shared constants and types for the frequency ranking block.
`default_nettype none
package frk_pkg;
    localparam int MAX_SAMPLES = 32;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic              absorb;  // a sample beat is being tallied
        logic              clear;   // drop all tallies
        logic              sort;    // one compare-exchange step
        logic              odd;     // odd pairs in this step
        logic              shift;   // move cells toward the head
    } cell_ctrl_t;

    // true if (ca, va) ranks ahead of (cb, vb)
    function automatic logic ranks_before(input logic [CNT_W-1:0] ca,
                                          input logic signed [VAL_W-1:0] va,
                                          input logic [CNT_W-1:0] cb,
                                          input logic signed [VAL_W-1:0] vb);
        if (ca != cb)
            return ca > cb;
        return va < vb;
    endfunction
endpackage
`default_nettype wire

@@ src/frequency_rank_of_values.sv @@
// Top level: sample intake, in-place odd-even sort, ranked emission.
//
// Input: one signed 16-bit sample per s_axis beat, s_axis_tlast on the last
// of a set. While loading, one sample is taken every cycle. Up to
// MAX_SAMPLES (32) samples are tallied; further ones are dropped and the
// overflowed flag is raised on every result of that set.
// After the last beat, the cell row runs MAX_SAMPLES odd-even exchange
// steps, then shifts its head out: one result per distinct value, highest
// count first, ties by lower value, m_axis_tlast on the final one.
// s_axis_tready is low from the last beat until the final result is
// loaded into the output register. A stalled receiver holds the output
// register and the row; nothing is lost. Reset clears all tallies and
// returns to load.
`default_nettype none
module frequency_rank_of_values (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_value
    input  wire logic        s_axis_tlast,   // last_item
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] event_value, [21:16] occurrences,
                                             // [22] overflowed, [23] zero
    output logic             m_axis_tlast    // last_result
);
    localparam int N = frk_pkg::MAX_SAMPLES;

    frk_pkg::state_t state_reg, state_next;
    frk_pkg::cell_ctrl_t ctrl;
    logic [frk_pkg::IDX_W-1:0] taken_reg, taken_next;
    logic [frk_pkg::IDX_W-1:0] step_reg, step_next;
    logic drop_reg, drop_next;
    logic signed [frk_pkg::VAL_W-1:0] head_val;
    logic [frk_pkg::CNT_W-1:0] head_cnt, next_cnt;
    logic [15:0] ov_reg;
    logic [5:0]  oc_reg;
    logic ofl_reg, olast_reg;
    logic ovalid_reg, ovalid_next;
    logic in_beat, keep, load_out;

    assign s_axis_tready = (state_reg == frk_pkg::ST_LOAD);
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign keep = in_beat && (taken_reg < frk_pkg::IDX_W'(N));
    assign load_out = (state_reg == frk_pkg::ST_EMIT) && (!ovalid_reg || m_axis_tready);

    frk_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (s_axis_tdata),
        .head_val (head_val),
        .head_cnt (head_cnt),
        .next_cnt (next_cnt)
    );

    always_comb begin
        state_next = state_reg;
        taken_next = taken_reg;
        step_next = step_reg;
        drop_next = drop_reg;
        ovalid_next = ovalid_reg;
        ctrl = '0;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            frk_pkg::ST_LOAD: begin
                ctrl.absorb = keep;
                if (keep)
                    taken_next = taken_reg + 1'b1;
                else if (in_beat)
                    drop_next = 1'b1;
                if (in_beat && s_axis_tlast) begin
                    state_next = frk_pkg::ST_SORT;
                    step_next = '0;
                end
            end
            frk_pkg::ST_SORT: begin
                ctrl.sort = 1'b1;
                ctrl.odd = step_reg[0];
                step_next = step_reg + 1'b1;
                if (step_reg == frk_pkg::IDX_W'(N - 1))
                    state_next = frk_pkg::ST_EMIT;
            end
            frk_pkg::ST_EMIT: begin
                if (load_out) begin
                    ctrl.shift = 1'b1;
                    ovalid_next = 1'b1;
                    if (next_cnt == '0) begin
                        // final result: clear for the next set
                        ctrl.shift = 1'b0;
                        ctrl.clear = 1'b1;
                        state_next = frk_pkg::ST_LOAD;
                        taken_next = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            default: state_next = frk_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frk_pkg::ST_LOAD;
            taken_reg <= '0;
            step_reg <= '0;
            drop_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            step_reg <= step_next;
            drop_reg <= drop_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            ov_reg <= head_val;
            oc_reg <= head_cnt;
            ofl_reg <= drop_reg;
            olast_reg <= (next_cnt == '0);
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {1'b0, ofl_reg, oc_reg, ov_reg};
    assign m_axis_tlast = olast_reg;
endmodule
`default_nettype wire

@@ src/frk_cell.sv @@
// One value-count cell: tally, odd-even sort exchange and head-ward shift.
`default_nettype none
module frk_cell (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire frk_pkg::cell_ctrl_t                 ctrl,
    input  wire logic                                is_even,
    input  wire logic signed [frk_pkg::VAL_W-1:0]    sample,
    input  wire logic                                any_match,
    input  wire logic                                first_free,
    input  wire logic signed [frk_pkg::VAL_W-1:0]    nb_lo_val,   // neighbor i-1
    input  wire logic        [frk_pkg::CNT_W-1:0]    nb_lo_cnt,
    input  wire logic signed [frk_pkg::VAL_W-1:0]    nb_hi_val,   // neighbor i+1
    input  wire logic        [frk_pkg::CNT_W-1:0]    nb_hi_cnt,
    output logic                                     match,
    output logic signed [frk_pkg::VAL_W-1:0]         val,
    output logic        [frk_pkg::CNT_W-1:0]         cnt
);
    logic signed [frk_pkg::VAL_W-1:0] val_reg, val_next;
    logic        [frk_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic lower;  // this cell is the lower one of its pair

    assign val = val_reg;
    assign cnt = cnt_reg;
    assign match = (cnt_reg != '0) && (val_reg == sample);
    assign lower = is_even ^ ctrl.odd;

    always_comb begin
        val_next = val_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear) begin
            cnt_next = '0;
        end else if (ctrl.absorb) begin
            if (match) begin
                if (cnt_reg != frk_pkg::COUNT_SAT)
                    cnt_next = cnt_reg + 1'b1;
            end else if (!any_match && first_free) begin
                val_next = sample;
                cnt_next = {{(frk_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
        end else if (ctrl.sort) begin
            // empty cells carry count zero and sink to the tail
            if (lower) begin
                if (frk_pkg::ranks_before(nb_hi_cnt, nb_hi_val, cnt_reg, val_reg)) begin
                    val_next = nb_hi_val;
                    cnt_next = nb_hi_cnt;
                end
            end else begin
                if (frk_pkg::ranks_before(cnt_reg, val_reg, nb_lo_cnt, nb_lo_val)) begin
                    val_next = nb_lo_val;
                    cnt_next = nb_lo_cnt;
                end
            end
        end else if (ctrl.shift) begin
            val_next = nb_hi_val;
            cnt_next = nb_hi_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (!aresetn)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end
endmodule
`default_nettype wire

@@ src/frk_chain.sv @@
// Row of cells with the free-slot and match networks.
`default_nettype none
module frk_chain (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire frk_pkg::cell_ctrl_t                 ctrl,
    input  wire logic signed [frk_pkg::VAL_W-1:0]    sample,
    output logic signed [frk_pkg::VAL_W-1:0]         head_val,
    output logic        [frk_pkg::CNT_W-1:0]         head_cnt,
    output logic        [frk_pkg::CNT_W-1:0]         next_cnt
);
    localparam int N = frk_pkg::MAX_SAMPLES;
    logic signed [frk_pkg::VAL_W-1:0] vals [N];
    logic        [frk_pkg::CNT_W-1:0] cnts [N];
    logic [N-1:0] hit_vec;
    logic any_match;

    assign any_match = |hit_vec;
    assign head_val = vals[0];
    assign head_cnt = cnts[0];

    // cells fill in order, so the first free one follows the last used one
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic ff;
        logic signed [frk_pkg::VAL_W-1:0] lo_v, hi_v;
        logic        [frk_pkg::CNT_W-1:0] lo_c, hi_c;
        if (i == 0) begin : g_first
            // end cells see a neighbor that never wins an exchange
            assign ff = (cnts[0] == '0);
            assign lo_v = {1'b1, {(frk_pkg::VAL_W-1){1'b0}}};
            assign lo_c = frk_pkg::COUNT_SAT;
        end else begin : g_mid
            assign ff = (cnts[i] == '0) && (cnts[i-1] != '0);
            assign lo_v = vals[i-1];
            assign lo_c = cnts[i-1];
        end
        if (i == N-1) begin : g_last
            assign hi_v = {1'b0, {(frk_pkg::VAL_W-1){1'b1}}};
            assign hi_c = '0;
        end else begin : g_hi
            assign hi_v = vals[i+1];
            assign hi_c = cnts[i+1];
        end
        frk_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .is_even    (1'((i % 2) == 0)),
            .sample     (sample),
            .any_match  (any_match),
            .first_free (ff),
            .nb_lo_val  (lo_v),
            .nb_lo_cnt  (lo_c),
            .nb_hi_val  (hi_v),
            .nb_hi_cnt  (hi_c),
            .match      (hit_vec[i]),
            .val        (vals[i]),
            .cnt        (cnts[i])
        );
    end

    if (N > 1) begin : g_nx
        assign next_cnt = cnts[1];
    end else begin : g_nx1
        assign next_cnt = '0;
    end
endmodule
`default_nettype wire

@@ src/frk_checker.sv @@
// Port-level checks for the frequency ranking block.
`default_nettype none
module frk_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[21:16] != 6'd0)
        else $error("zero count result");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("intake open during emission");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[23])
        else $error("pad bit set");
endmodule

bind frequency_rank_of_values frk_checker u_frk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ tb/tb_frequency_rank_of_values.sv @@
// Testbench for the frequency ranking block: queued sample driver, ranked result monitor.
`timescale 1ns / 1ps
module tb_frequency_rank_of_values;

    typedef struct {
        logic signed [15:0] value;
        logic               last;
    } sample_t;

    typedef struct {
        logic signed [15:0] value;
        logic [5:0]         count;
        logic               ovf;
        logic               last;
    } rank_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    frequency_rank_of_values DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    sample_t pending_samples[$];
    rank_t   expected_ranks[$];
    int      errors = 0;
    int      cycles = 0;
    bit      stim_done = 0;
    bit      hold_active = 1'b0;   // long receiver stall

    // tally state of the set being loaded
    logic signed [15:0] tally_val[frk_pkg::MAX_SAMPLES];
    logic [5:0]         tally_cnt[frk_pkg::MAX_SAMPLES];
    int                 n_distinct = 0;
    int                 n_taken = 0;
    logic               dropped = 1'b0;

    task automatic tally_sample(input sample_t s);
        int   i, k, best;
        bit   hit;
        bit   used[frk_pkg::MAX_SAMPLES];
        rank_t r;
        hit = 0;
        if (n_taken >= frk_pkg::MAX_SAMPLES) begin
            dropped = 1'b1;
        end else begin
            n_taken++;
            for (i = 0; i < n_distinct; i++)
                if (!hit && tally_val[i] == s.value) begin
                    hit = 1;
                    if (tally_cnt[i] != frk_pkg::COUNT_SAT) tally_cnt[i]++;
                end
            if (!hit) begin
                tally_val[n_distinct] = s.value;
                tally_cnt[n_distinct] = 1;
                n_distinct++;
            end
        end
        if (!s.last) return;
        for (i = 0; i < frk_pkg::MAX_SAMPLES; i++) used[i] = 0;
        for (k = 0; k < n_distinct; k++) begin
            best = -1;
            for (i = 0; i < n_distinct; i++)
                if (!used[i] && (best < 0 || tally_cnt[i] > tally_cnt[best] ||
                    (tally_cnt[i] == tally_cnt[best] && tally_val[i] < tally_val[best])))
                    best = i;
            used[best] = 1;
            r.value = tally_val[best];
            r.count = tally_cnt[best];
            r.ovf   = dropped;
            r.last  = (k == n_distinct - 1);
            expected_ranks.push_back(r);
        end
        n_distinct = 0;
        n_taken = 0;
        dropped = 1'b0;
    endtask

    task automatic push_sample(input logic [15:0] v, input logic l);
        sample_t s;
        s.value = v;
        s.last = l;
        pending_samples.push_back(s);
    endtask

    // a set of n samples drawn from a pool of the given size, or fully random values for pool 0
    task automatic push_set(input int n, input int pool);
        int i;
        logic [15:0] base;
        logic [15:0] vals[8];
        base = 16'($urandom);
        for (i = 0; i < 8; i++) vals[i] = (i < 2) ? 16'($urandom) : base + i[15:0];
        for (i = 0; i < n; i++)
            push_sample((pool == 0) ? 16'($urandom) : vals[$urandom_range(pool - 1, 0)],
                        i == n - 1);
    endtask

    // long receiver stall right after reset, counted here
    initial begin
        wait (aresetn);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tally_sample(pending_samples.pop_front());
                s_gap = $urandom_range(10, 0);
                if ($urandom_range(3, 0) == 0) s_gap = 0;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_samples[0].value;
                    s_axis_tlast  <= pending_samples[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        rank_t e;
        cycles++;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_ranks.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                end else begin
                    e = expected_ranks.pop_front();
                    if (m_axis_tdata[15:0] !== e.value || m_axis_tdata[21:16] !== e.count ||
                        m_axis_tdata[22] !== e.ovf || m_axis_tdata[23] !== 1'b0 ||
                        m_axis_tlast !== e.last) begin
                        errors++;
                        $display("%0t: expected value %h count %0d ovf %b last %b, got %h last %b",
                                 $time, e.value, e.count, e.ovf, e.last, m_axis_tdata,
                                 m_axis_tlast);
                    end
                end
                m_gap = $urandom_range(10, 0);
                if ($urandom_range(3, 0) == 0) m_gap = 0;
            end
            if (hold_active) begin
                m_axis_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        // directed sets
        push_sample(16'h8000, 1);                       // single sample
        push_sample(16'h7fff, 0); push_sample(16'h8000, 0);
        push_sample(16'h7fff, 0); push_sample(16'hffff, 0);
        push_sample(16'h0000, 1);                       // ties ordered by value
        for (i = 0; i < 35; i++) push_sample(16'h0005, i == 34);  // overflow, same value
        for (i = 0; i < 34; i++) push_sample(16'(i * 997), i == 33); // overflow, 32 distinct
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_samples.size() + expected_ranks.size() > 0 && cycles < 200000)
            @(posedge aclk);
        // random sets, mostly small
        for (i = 0; i < 5; i++)
            push_set($urandom_range(12, 1), $urandom_range(8, 0));
        while ((pending_samples.size() > 0 || expected_ranks.size() > 0) && cycles < 200000)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done || cycles >= 200000);
        if (!stim_done) begin
            $display("frequency_rank_of_values test failed");
            $finish;
        end
        if (errors == 0 && expected_ranks.size() == 0)
            $display("frequency_rank_of_values test passed");
        else
            $display("frequency_rank_of_values test failed");
        $finish;
    end
endmodule
